// File: hdl/msb_pkg.sv
// Shared constants, command and register codes, and inter-module structs
// for the masked bilinear sampler. No dependencies.
package msb_pkg;

   // Image storage limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Four parity banks: bank index is {row[0], col[0]}
   localparam int NUM_BANKS  = 4;
   localparam int BANK_SEL_W = 2;
   localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
   localparam int BANK_DEPTH = 1 << BANK_AW;

   // Field widths
   localparam int CMD_W     = 2;
   localparam int POS_W     = 10;
   localparam int PIX_W     = 8;
   localparam int SAMPLE_W  = 19;
   localparam int FRAC_W    = 8;
   localparam int DIM_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int VALUE_W   = 16;

   // Derived arithmetic widths
   localparam int COORD_W    = SAMPLE_W + 1 - FRAC_W;
   localparam int HALF_PIXEL = 1 << (FRAC_W - 1);
   localparam int WEIGHT_W   = 2 * FRAC_W + 1;
   localparam int PROD_W     = PIX_W + WEIGHT_W;
   localparam int SUM_W      = PROD_W + 2;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;

   // Store write request
   typedef struct packed {
      logic                  en;
      logic                  is_label;
      logic [BANK_SEL_W-1:0] bank;
      logic [BANK_AW-1:0]    addr;
      logic [PIX_W-1:0]      pixel;
      logic                  mark;
   } msb_wr_type;

   // Store read addresses, one per bank
   typedef struct packed {
      logic [NUM_BANKS-1:0][BANK_AW-1:0] addr;
   } msb_rd_type;

   // Store read data, one word per bank
   typedef struct packed {
      logic [NUM_BANKS-1:0][PIX_W-1:0] pixel;
      logic [NUM_BANKS-1:0]            mark;
   } msb_rdata_type;

   // Stage enables for the interpolation pipeline
   typedef struct packed {
      logic load;
      logic addr;
      logic mult;
      logic sum;
   } msb_ctl_type;

endpackage

// File: hdl/msb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module msb_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/msb_store.sv
// Pixel and label storage: four parity banks of each, plus the label clear pass.
// Depends on msb_pkg and msb_ram.
module msb_store import msb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  msb_wr_type    wr,
   input  msb_rd_type    rd,
   output msb_rdata_type rdata,
   output logic          clearing
);

   logic               clearing_ff;
   logic               clearing_in;
   logic [BANK_AW-1:0] clr_addr_ff;
   logic [BANK_AW-1:0] clr_addr_in;

   assign clr_addr_in = clearing_ff ? clr_addr_ff + BANK_AW'(1) : clr_addr_ff;
   assign clearing_in = clearing_ff & ~(&clr_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign clearing = clearing_ff;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic hit;
      assign hit = wr.en & (wr.bank == BANK_SEL_W'(b));

      msb_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_img (
         .clock   (clock),
         .wr_en   (hit & ~wr.is_label),
         .wr_addr (wr.addr),
         .wr_data (wr.pixel),
         .rd_addr (rd.addr[b]),
         .rd_data (rdata.pixel[b])
      );

      // Sweep zeros through every label entry after reset
      msb_ram #(.WIDTH(1), .DEPTH(BANK_DEPTH)) u_lbl (
         .clock   (clock),
         .wr_en   (clearing_ff | (hit & wr.is_label)),
         .wr_addr (clearing_ff ? clr_addr_ff : wr.addr),
         .wr_data (clearing_ff ? 1'b0 : wr.mark),
         .rd_addr (rd.addr[b]),
         .rd_data (rdata.mark[b])
      );
   end

   a_no_write_while_clearing: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !clearing_ff)
      else $error("store write during label clear pass");

   a_clear_runs_full: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> $past(&clr_addr_ff))
      else $error("label clear pass ended early");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clearing_ff |=> !clearing_ff)
      else $error("label clear pass restarted without reset");

endmodule

// File: hdl/msb_interp.sv
// Bilinear interpolation pipeline: neighbour addressing, weights, products, sum.
// Depends on msb_pkg; reads the parity banks in msb_store.
module msb_interp import msb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  msb_ctl_type                ctl,
   input  logic signed [SAMPLE_W-1:0] sample_x,
   input  logic signed [SAMPLE_W-1:0] sample_y,
   input  logic                       unlabeled_only,
   input  logic [DIM_W-1:0]           image_width,
   input  logic [DIM_W-1:0]           image_height,
   input  msb_rdata_type              rdata,
   output msb_rd_type                 rd,
   output logic                       rsp_valid,
   output logic [VALUE_W-1:0]         rsp_value
);

   function automatic logic coord_ok(logic [COORD_W-1:0] c, logic [DIM_W-1:0] dim,
                                     int maxv);
      return !c[COORD_W-1] && (32'(c) < 32'(dim)) && (32'(c) < 32'(maxv));
   endfunction

   logic [SAMPLE_W-1:0] x_ff, y_ff;
   logic                unl_ff;

   logic [SAMPLE_W:0]   u, v;
   logic [FRAC_W-1:0]   fx, fy;
   logic [FRAC_W:0]     gx, gy;
   logic [COORD_W-1:0]  c0, c1, r0, r1;
   logic                c0_ok, c1_ok, r0_ok, r1_ok;

   logic [NUM_BANKS-1:0][WEIGHT_W-1:0] w_in, w_ff;
   logic [NUM_BANKS-1:0]               ok_in, ok_ff;
   logic [BANK_SEL_W-1:0]              par_ff;

   logic [NUM_BANKS-1:0][PROD_W-1:0]   prod_in, prod_ff;
   logic [SUM_W-1:0]                   sum;
   logic [VALUE_W-1:0]                 value_ff;
   logic                               valid_ff;

   // Shift to pixel-centre space; floor cell index and fraction
   assign u  = (SAMPLE_W + 1)'({x_ff[SAMPLE_W-1], x_ff}) - (SAMPLE_W + 1)'(HALF_PIXEL);
   assign v  = (SAMPLE_W + 1)'({y_ff[SAMPLE_W-1], y_ff}) - (SAMPLE_W + 1)'(HALF_PIXEL);
   assign fx = u[FRAC_W-1:0];
   assign fy = v[FRAC_W-1:0];
   assign gx = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, fx};
   assign gy = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, fy};
   assign c0 = u[SAMPLE_W:FRAC_W];
   assign r0 = v[SAMPLE_W:FRAC_W];
   assign c1 = c0 + COORD_W'(1);
   assign r1 = r0 + COORD_W'(1);

   assign c0_ok = coord_ok(c0, image_width, MAX_WIDTH);
   assign c1_ok = coord_ok(c1, image_width, MAX_WIDTH);
   assign r0_ok = coord_ok(r0, image_height, MAX_HEIGHT);
   assign r1_ok = coord_ok(r1, image_height, MAX_HEIGHT);

   // Neighbour order: (r0,c0), (r0,c1), (r1,c0), (r1,c1)
   assign ok_in = {r1_ok & c1_ok, r1_ok & c0_ok, r0_ok & c1_ok, r0_ok & c0_ok};
   assign w_in[0] = WEIGHT_W'(gx) * WEIGHT_W'(gy);
   assign w_in[1] = WEIGHT_W'(fx) * WEIGHT_W'(gy);
   assign w_in[2] = WEIGHT_W'(gx) * WEIGHT_W'(fy);
   assign w_in[3] = WEIGHT_W'(fx) * WEIGHT_W'(fy);

   // Each bank gets the one of the two rows and columns with its parity
   always_comb begin
      logic [COORD_W-1:0] rsel, csel;
      logic [ROW_W-1:0]   rfull;
      logic [COL_W-1:0]   cfull;
      rd = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         rsel  = (r0[0] == b[1]) ? r0 : r1;
         csel  = (c0[0] == b[0]) ? c0 : c1;
         rfull = ROW_W'(rsel);
         cfull = COL_W'(csel);
         rd.addr[b] = {rfull[ROW_W-1:1], cfull[COL_W-1:1]};
      end
   end

   // Route bank data back to neighbours, drop out-of-range and masked ones, weight
   always_comb begin
      logic [BANK_SEL_W-1:0] bank;
      logic [PIX_W-1:0]      pix;
      for (int n = 0; n < NUM_BANKS; n++) begin
         bank = par_ff ^ BANK_SEL_W'(n);
         pix  = rdata.pixel[bank];
         if (!ok_ff[n] || (unl_ff && rdata.mark[bank])) begin
            pix = '0;
         end
         prod_in[n] = PROD_W'(pix) * PROD_W'(w_ff[n]);
      end
   end

   assign sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1])
              + SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff   <= sample_x;
         y_ff   <= sample_y;
         unl_ff <= unlabeled_only;
      end
      if (ctl.addr) begin
         w_ff   <= w_in;
         ok_ff  <= ok_in;
         par_ff <= {r0[0], c0[0]};
      end
      if (ctl.mult) begin
         prod_ff <= prod_in;
      end
      if (ctl.sum) begin
         value_ff <= sum[FRAC_W +: VALUE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.sum;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;

endmodule

// File: hdl/masked_bilinear_sampler.sv
// Top level of the masked bilinear sampler: command FSM, dimension registers.
// Depends on msb_pkg, msb_store and msb_interp.
//
// Usage:
//  - Commands enter on the req_ ports and are taken at an edge where start is
//    high and busy is low. Command 0 writes a pixel, 1 writes a label mark,
//    2 samples the image; command 3 is dropped.
//  - Writes give no result; busy stays low.
//  - A sample keeps busy high through the address, multiply and sum states;
//    its result is on rsp_sample_value with rsp_valid, registered from the
//    sum state. A new command can be taken in the cycle in which the result is
//    shown, so a sample ends before the next command; writes run at one per
//    cycle while busy is low.
//  - The four neighbours come from four row/column parity banks in one read;
//    the single read port per bank and the multiply pipeline set the latency.
//  - The receiver cannot stall: each result is shown for exactly one cycle.
//  - The csr_ channel writes image_width (index 0) and image_height (index 1);
//    csr_ready is always high. Other indexes are ignored. Both reset to 1024.
//  - After reset the label mask is cleared by a pass over every one of the
//    BANK_DEPTH entries (262144 at the default size), one entry per bank per
//    cycle; busy is high throughout and configuration writes are still taken.
module masked_bilinear_sampler import msb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic [POS_W-1:0]           req_pix_col,
   input  logic [POS_W-1:0]           req_pix_row,
   input  logic [PIX_W-1:0]           req_pixel_value,
   input  logic                       req_label_mark,
   input  logic signed [SAMPLE_W-1:0] req_sample_x,
   input  logic signed [SAMPLE_W-1:0] req_sample_y,
   input  logic                       req_unlabeled_only,
   output logic                       rsp_valid,
   output logic [VALUE_W-1:0]         rsp_sample_value,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [DIM_W-1:0]           csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ADDR = 4'b0010,
      ST_MULT = 4'b0100,
      ST_SUM  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] width_ff, height_ff;
   logic             clearing;
   logic             accept;
   logic             in_range;
   logic [COL_W-1:0] col_idx;
   logic [ROW_W-1:0] row_idx;

   msb_wr_type    wr;
   msb_rd_type    rd;
   msb_rdata_type rdata;
   msb_ctl_type   ctl;

   assign busy      = clearing | (state_ff != ST_IDLE);
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == CMD_SAMPLE) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: state_in = ST_MULT;
         ST_MULT: state_in = ST_SUM;
         ST_SUM:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIDTH:  width_ff  <= csr_wdata;
               REG_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign ctl.load = accept & (req_cmd == CMD_SAMPLE);
   assign ctl.addr = (state_ff == ST_ADDR);
   assign ctl.mult = (state_ff == ST_MULT);
   assign ctl.sum  = (state_ff == ST_SUM);

   // Writes go straight to the bank picked by row and column parity
   assign in_range = (32'(req_pix_col) < 32'(MAX_WIDTH)) &&
                     (32'(req_pix_row) < 32'(MAX_HEIGHT));
   assign col_idx  = COL_W'(req_pix_col);
   assign row_idx  = ROW_W'(req_pix_row);

   assign wr.en       = accept & in_range &
                        ((req_cmd == CMD_PIXEL) || (req_cmd == CMD_MARK));
   assign wr.is_label = (req_cmd == CMD_MARK);
   assign wr.bank     = {row_idx[0], col_idx[0]};
   assign wr.addr     = {row_idx[ROW_W-1:1], col_idx[COL_W-1:1]};
   assign wr.pixel    = req_pixel_value;
   assign wr.mark     = req_label_mark;

   msb_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd       (rd),
      .rdata    (rdata),
      .clearing (clearing)
   );

   msb_interp u_interp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sample_x       (req_sample_x),
      .sample_y       (req_sample_y),
      .unlabeled_only (req_unlabeled_only),
      .image_width    (width_ff),
      .image_height   (height_ff),
      .rdata          (rdata),
      .rd             (rd),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_sample_value)
   );

   a_sample_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_SAMPLE) |-> ##4 rsp_valid)
      else $error("sample item produced no result");

   a_write_gives_none: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd != CMD_SAMPLE) |-> ##4 !rsp_valid)
      else $error("non-sample item produced a result");

   a_result_after_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_SUM))
      else $error("result strobe without a sum stage");

endmodule
